/* sv/c3v_pkg.sv */
// Shared types and constants for the 3x3 valid-convolution stream block.
package c3v_pkg;

    localparam int PIX_BITS  = 16;
    localparam int COEF_BITS = 16;
    localparam int PROD_BITS = PIX_BITS + COEF_BITS;
    localparam int SUM_BITS  = 35;
    localparam int CNT_BITS  = 6;
    localparam int KROW_BITS = 48;
    localparam int APB_DW    = 64;
    localparam int APB_AW    = 6;
    localparam int IDX_BITS  = 3;

    // register indexes, byte address = 8 * index
    localparam logic [IDX_BITS-1:0] REG_KERNEL_TOP    = 3'd0;
    localparam logic [IDX_BITS-1:0] REG_KERNEL_MIDDLE = 3'd1;
    localparam logic [IDX_BITS-1:0] REG_KERNEL_BOTTOM = 3'd2;
    localparam logic [IDX_BITS-1:0] REG_IMAGE_WIDTH   = 3'd3;
    localparam logic [IDX_BITS-1:0] REG_IMAGE_HEIGHT  = 3'd4;

    localparam logic [CNT_BITS-1:0] SIZE_RESET = 6'd28;
    localparam logic [CNT_BITS-1:0] SIZE_MIN   = 6'd3;

    typedef logic signed [PIX_BITS-1:0]  t_pixel;
    typedef logic signed [COEF_BITS-1:0] t_coef;
    typedef logic signed [PROD_BITS-1:0] t_prod;
    typedef logic signed [SUM_BITS-1:0]  t_sum;

    // one window column, index 0 is the top row
    typedef t_pixel [2:0] t_column;
    typedef t_coef  [2:0] t_coef_col;

    typedef struct packed {
        logic signed [PIX_BITS-1:0] pixel_value;
        logic                       frame_start;
    } t_pix_in;

    typedef struct packed {
        logic signed [SUM_BITS-1:0] window_sum;
        logic                       frame_last;
    } t_res_out;

endpackage

/* sv/c3v_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module c3v_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read returns the old word on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/c3v_cell.sv */
// One window column cell: holds a column, multiplies it by its coefficients, sums.
module c3v_cell (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_shift,
    input  c3v_pkg::t_column     i_col,
    output c3v_pkg::t_column     o_col,
    input  c3v_pkg::t_coef_col   i_coef,
    input  logic                 i_mul_en,
    input  logic                 i_sum_en,
    output c3v_pkg::t_sum        o_sum
);
    import c3v_pkg::*;

    t_column r_col;
    t_prod   r_prod [3];
    t_sum    r_sum;
    t_sum    n_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
        end else if (i_shift) begin
            r_col <= i_col;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_mul_en) begin
            for (int r = 0; r < 3; r++) begin
                r_prod[r] <= t_prod'($signed(r_col[r])) * t_prod'($signed(i_coef[r]));
            end
        end
    end

    always_comb begin
        n_sum = t_sum'(r_prod[0]) + t_sum'(r_prod[1]) + t_sum'(r_prod[2]);
    end

    always_ff @(posedge i_clk) begin
        if (i_sum_en) begin
            r_sum <= n_sum;
        end
    end

    assign o_col = r_col;
    assign o_sum = r_sum;

endmodule

/* sv/conv3x3_valid_stream.sv */
// 3x3 valid convolution over a raster pixel stream: top level.
//
// Pixels enter on the in channel (valid/ready), one beat per pixel in raster
// order; frame_start on a beat puts that pixel at row 0, column 0. Once the
// pixel sits at row >= 2 and column >= 2 it completes a window, and one beat
// leaves on the out channel with the exact 35-bit sum of the nine products
// and frame_last on the final window of the frame. Other pixels give no beat.
// Throughput is one pixel per clock; the line store is a single RAM holding
// both previous rows at one column per word, read once and written once per
// pixel. From input beat to output valid a pixel passes line read, window
// shift, products, column sums and final add, each in its own register.
// After reset the line store is swept to zero, one column per cycle, over all
// MAX_WIDTH words; no pixel is taken then, configuration writes still are.
// When the receiver stalls, beats stay in the output register and the stages
// in front fill up, after which in_ready drops until the stall clears.
// Kernel and size registers sit on the APB port at byte address 8*index.
module conv3x3_valid_stream #(
    parameter int MAX_WIDTH = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  c3v_pkg::t_pix_in                  i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output c3v_pkg::t_res_out                 o_out_data,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [c3v_pkg::APB_AW-1:0]        paddr,
    input  logic [c3v_pkg::APB_DW-1:0]        pwdata,
    output logic [c3v_pkg::APB_DW-1:0]        prdata,
    output logic                              pready
);
    import c3v_pkg::*;

    localparam int AW      = $clog2(MAX_WIDTH);
    localparam int WORD_W  = 2 * PIX_BITS;

    // ---------------- configuration ----------------
    logic [KROW_BITS-1:0] r_krow [3];
    logic [CNT_BITS-1:0]  r_img_w;
    logic [CNT_BITS-1:0]  r_img_h;
    logic [IDX_BITS-1:0]  reg_idx;
    logic                 cfg_wr;

    assign reg_idx = paddr[APB_AW-1:APB_AW-IDX_BITS];
    assign cfg_wr  = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_krow[0] <= '0;
            r_krow[1] <= '0;
            r_krow[2] <= '0;
            r_img_w   <= SIZE_RESET;
            r_img_h   <= SIZE_RESET;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_KERNEL_TOP:    r_krow[0] <= pwdata[KROW_BITS-1:0];
                REG_KERNEL_MIDDLE: r_krow[1] <= pwdata[KROW_BITS-1:0];
                REG_KERNEL_BOTTOM: r_krow[2] <= pwdata[KROW_BITS-1:0];
                REG_IMAGE_WIDTH:   r_img_w   <= pwdata[CNT_BITS-1:0];
                REG_IMAGE_HEIGHT:  r_img_h   <= pwdata[CNT_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_KERNEL_TOP:    prdata = APB_DW'(r_krow[0]);
            REG_KERNEL_MIDDLE: prdata = APB_DW'(r_krow[1]);
            REG_KERNEL_BOTTOM: prdata = APB_DW'(r_krow[2]);
            REG_IMAGE_WIDTH:   prdata = APB_DW'(r_img_w);
            REG_IMAGE_HEIGHT:  prdata = APB_DW'(r_img_h);
            default:           prdata = '0;
        endcase
    end

    // ---------------- pipeline handshake ----------------
    logic r_a_valid, r_b_valid, r_c_valid, r_d_valid, r_out_valid;
    logic ld_a, ld_b, ld_c, ld_d, ld_e;
    logic accept, shift;
    logic r_clr_busy;
    logic [AW-1:0] r_clr_addr;

    logic r_b_prod;

    assign ld_e   = !r_out_valid || i_out_ready;
    assign ld_d   = !r_d_valid || ld_e;
    assign ld_c   = !r_c_valid || ld_d;
    assign ld_b   = !(r_b_valid && r_b_prod) || ld_c;
    assign ld_a   = !r_a_valid || ld_b;
    assign o_in_ready = ld_a && !r_clr_busy;
    assign accept = i_in_valid && o_in_ready;
    assign shift  = r_a_valid && ld_b;

    // ---------------- position counters ----------------
    logic [CNT_BITS-1:0] r_row, r_col;
    logic [CNT_BITS-1:0] row_cur, col_raw, col_eff;
    logic [CNT_BITS:0]   w_eff, h_eff, col_inc, row_inc;
    logic                col_wrap, row_wrap, produce, last;

    always_comb begin
        if (r_img_w < SIZE_MIN) begin
            w_eff = (CNT_BITS+1)'(SIZE_MIN);
        end else if (32'(r_img_w) > MAX_WIDTH) begin
            w_eff = (CNT_BITS+1)'(MAX_WIDTH);
        end else begin
            w_eff = (CNT_BITS+1)'(r_img_w);
        end
        h_eff = (r_img_h < SIZE_MIN) ? (CNT_BITS+1)'(SIZE_MIN) : (CNT_BITS+1)'(r_img_h);

        row_cur = i_in_data.frame_start ? '0 : r_row;
        col_raw = i_in_data.frame_start ? '0 : r_col;
        col_eff = (32'(col_raw) >= MAX_WIDTH) ? CNT_BITS'(MAX_WIDTH - 1) : col_raw;

        col_inc  = (CNT_BITS+1)'(col_eff) + 1'b1;
        row_inc  = (CNT_BITS+1)'(row_cur) + 1'b1;
        col_wrap = col_inc >= w_eff;
        row_wrap = row_inc >= h_eff;
        produce  = (row_cur >= CNT_BITS'(2)) && (col_eff >= CNT_BITS'(2));
        last     = row_wrap && col_wrap;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
        end else if (accept) begin
            if (col_wrap) begin
                r_col <= '0;
                r_row <= row_wrap ? '0 : row_inc[CNT_BITS-1:0];
            end else begin
                r_col <= col_inc[CNT_BITS-1:0];
                r_row <= row_cur;
            end
        end
    end

    // ---------------- line store ----------------
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [WORD_W-1:0] ram_wdata, ram_rdata;
    logic [AW-1:0]     rd_addr;

    logic [AW-1:0]     r_a_addr;
    t_pixel            r_a_pix;
    logic              r_a_prod, r_a_last;
    logic              r_byp;
    logic [WORD_W-1:0] r_byp_word;
    logic [WORD_W-1:0] a_word;
    t_pixel            a_top, a_mid;
    logic [WORD_W-1:0] a_wb_word;

    assign rd_addr   = AW'(col_eff);
    assign a_word    = r_byp ? r_byp_word : ram_rdata;
    assign a_top     = t_pixel'(a_word[PIX_BITS-1:0]);
    assign a_mid     = t_pixel'(a_word[WORD_W-1:PIX_BITS]);
    // older row moves down a bank, new pixel becomes the previous row
    assign a_wb_word = {r_a_pix, a_mid};

    assign ram_we    = r_clr_busy || shift;
    assign ram_waddr = r_clr_busy ? r_clr_addr : r_a_addr;
    assign ram_wdata = r_clr_busy ? '0 : a_wb_word;

    c3v_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (accept),
        .i_raddr (rd_addr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == AW'(MAX_WIDTH - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    // stage A: pixel waits for its line word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (ld_a) begin
            r_a_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_a_pix    <= i_in_data.pixel_value;
            r_a_addr   <= rd_addr;
            r_a_prod   <= produce;
            r_a_last   <= last;
            // write-back of the pixel ahead hits the same column this edge
            r_byp      <= shift && (r_a_addr == rd_addr);
            r_byp_word <= a_wb_word;
        end
    end

    // stage B: window lives in the cell chain
    logic r_b_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (ld_b) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (shift) begin
            r_b_prod <= r_a_prod;
            r_b_last <= r_a_last;
        end
    end

    // stages C and D: products and column sums inside the cells
    logic r_c_last, r_d_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
        end else begin
            if (ld_c) begin
                r_c_valid <= r_b_valid && r_b_prod;
            end
            if (ld_d) begin
                r_d_valid <= r_c_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld_c) begin
            r_c_last <= r_b_last;
        end
        if (ld_d) begin
            r_d_last <= r_c_last;
        end
    end

    // ---------------- cell chain ----------------
    // cell 2 takes the current column, cell 0 holds the oldest (left) column
    t_column   cur_col;
    t_column   cell_col  [3];
    t_coef_col cell_coef [3];
    t_sum      cell_sum  [3];

    always_comb begin
        cur_col[0] = a_top;
        cur_col[1] = a_mid;
        cur_col[2] = r_a_pix;
        for (int j = 0; j < 3; j++) begin
            for (int r = 0; r < 3; r++) begin
                cell_coef[j][r] = t_coef'(r_krow[r][j*COEF_BITS +: COEF_BITS]);
            end
        end
    end

    for (genvar j = 0; j < 3; j++) begin : g_cell
        t_column cell_in;

        if (j == 2) begin : g_head
            assign cell_in = cur_col;
        end else begin : g_link
            assign cell_in = cell_col[j+1];
        end

        c3v_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_shift  (shift),
            .i_col    (cell_in),
            .o_col    (cell_col[j]),
            .i_coef   (cell_coef[j]),
            .i_mul_en (ld_c),
            .i_sum_en (ld_d),
            .o_sum    (cell_sum[j])
        );
    end

    // ---------------- output register ----------------
    t_res_out r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ld_e) begin
            r_out_valid <= r_d_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld_e) begin
            r_out_data.window_sum <= cell_sum[0] + cell_sum[1] + cell_sum[2];
            r_out_data.frame_last <= r_d_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

/* tb/sv/tb_conv3x3_valid_stream.sv */
// Self-checking testbench for the 3x3 valid-convolution pixel stream block.
`timescale 1ns / 1ps

module tb_conv3x3_valid_stream;
    import c3v_pkg::*;

    localparam int MAX_W       = 32;
    localparam int HOLD_CYCLES = 300;
    localparam int LIMIT       = 300000;
    localparam int SETTLE      = 12;
    localparam int ITEMS       = 450;

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_in_valid  = 1'b0;
    logic              o_in_ready;
    t_pix_in           i_in_data   = '0;
    logic              o_out_valid;
    logic              i_out_ready = 1'b0;
    t_res_out          o_out_data;
    logic              psel        = 1'b0;
    logic              penable     = 1'b0;
    logic              pwrite      = 1'b0;
    logic [APB_AW-1:0] paddr       = '0;
    logic [APB_DW-1:0] pwdata      = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    conv3x3_valid_stream #(.MAX_WIDTH(MAX_W)) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #5 i_clk = ~i_clk;

    // shadow of the block's registers and pixel state
    logic [KROW_BITS-1:0] kern [3];
    logic [CNT_BITS-1:0]  cfg_w = SIZE_RESET;
    logic [CNT_BITS-1:0]  cfg_h = SIZE_RESET;
    t_pixel               line_mem [2*MAX_W];
    t_pixel               win_col [6];
    int unsigned          row_cnt = 0;
    int unsigned          col_cnt = 0;

    t_pix_in     pix_q [$];
    t_res_out    sum_q [$];
    int unsigned items_total = 0;
    int unsigned pix_count   = 0;
    int unsigned res_count   = 0;
    int unsigned err_count   = 0;
    int unsigned cfg_count   = 0;
    int unsigned cycle_cnt   = 0;

    int unsigned send_idle = 24;
    int unsigned recv_idle = 24;
    logic        hold_req  = 1'b0;
    logic        hold_done = 1'b0;
    int unsigned hold_left = 0;

    initial begin
        for (int i = 0; i < 3; i++) kern[i] = '0;
        for (int i = 0; i < 2*MAX_W; i++) line_mem[i] = '0;
        for (int i = 0; i < 6; i++) win_col[i] = '0;
    end

    function automatic int unsigned eff_w(input logic [CNT_BITS-1:0] w);
        if (w < SIZE_MIN) return 32'(SIZE_MIN);
        if (w > MAX_W) return MAX_W;
        return 32'(w);
    endfunction

    function automatic int unsigned eff_h(input logic [CNT_BITS-1:0] h);
        return (h < SIZE_MIN) ? 32'(SIZE_MIN) : 32'(h);
    endfunction

    // coefficient c of kernel row r, left tap in the low bits
    function automatic longint kernel_tap(input int r, input int c);
        return longint'($signed(kern[r][c*COEF_BITS +: COEF_BITS]));
    endfunction

    // advance the shadow state by one pixel; queue the window sum if it closes one
    function automatic void convolve_pixel(input t_pix_in px);
        int unsigned w, h, col, row;
        t_pixel      cur [3];
        longint      acc;
        t_res_out    res;
        w = eff_w(cfg_w);
        h = eff_h(cfg_h);
        if (px.frame_start) begin
            row_cnt = 0;
            col_cnt = 0;
        end
        col = (col_cnt >= MAX_W) ? MAX_W - 1 : col_cnt;
        row = row_cnt;
        cur[0] = line_mem[col];
        cur[1] = line_mem[MAX_W + col];
        cur[2] = px.pixel_value;
        if (row >= 2 && col >= 2) begin
            acc = 0;
            for (int r = 0; r < 3; r++) begin
                acc += longint'(win_col[r]) * kernel_tap(r, 0);
                acc += longint'(win_col[3 + r]) * kernel_tap(r, 1);
                acc += longint'(cur[r]) * kernel_tap(r, 2);
            end
            res.window_sum = t_sum'(acc);
            res.frame_last = (row + 1 >= h) && (col + 1 >= w);
            sum_q.push_back(res);
        end
        line_mem[col]         = cur[1];
        line_mem[MAX_W + col] = cur[2];
        for (int i = 0; i < 3; i++) begin
            win_col[i]     = win_col[3 + i];
            win_col[3 + i] = cur[i];
        end
        if (col + 1 >= w) begin
            col_cnt = 0;
            row_cnt = (row + 1 >= h) ? 0 : (row + 1) & 6'h3f;
        end else begin
            col_cnt = col + 1;
            row_cnt = row;
        end
    endfunction

    task automatic report_mismatch(input string msg);
        err_count++;
        if (err_count <= 100) $display("[%0t] MISMATCH: %s", $time, msg);
    endtask

    // pixel driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                convolve_pixel(i_in_data);
                pix_count <= pix_count + 1;
            end
            if (!i_in_valid || o_in_ready) begin
                if (pix_q.size() != 0 && $urandom_range(99) >= send_idle) begin
                    i_in_valid <= 1'b1;
                    i_in_data  <= pix_q.pop_front();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor and receiver back-pressure
    always @(posedge i_clk) begin
        t_res_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            res_count++;
            if (sum_q.size() == 0) begin
                report_mismatch($sformatf("unexpected beat sum=%0d last=%0b",
                    o_out_data.window_sum, o_out_data.frame_last));
            end else begin
                want = sum_q.pop_front();
                if (o_out_data.window_sum !== want.window_sum)
                    report_mismatch($sformatf("window_sum got %0d want %0d (beat %0d)",
                        o_out_data.window_sum, want.window_sum, res_count));
                if (o_out_data.frame_last !== want.frame_last)
                    report_mismatch($sformatf("frame_last got %0b want %0b (beat %0d)",
                        o_out_data.frame_last, want.frame_last, res_count));
            end
        end
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else if (hold_req && !hold_done) begin
            hold_left   <= HOLD_CYCLES;
            hold_done   <= 1'b1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    always @(posedge i_clk) cycle_cnt <= cycle_cnt + 1;

    initial begin
        wait (cycle_cnt >= LIMIT);
        $display("timeout after %0d cycles, %0d windows still pending", cycle_cnt,
            sum_q.size());
        $display("tb_conv3x3_valid_stream: done, errors");
        $finish;
    end

    task automatic write_reg(input logic [IDX_BITS-1:0] idx, input logic [APB_DW-1:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_KERNEL_TOP:    kern[0] = val[KROW_BITS-1:0];
            REG_KERNEL_MIDDLE: kern[1] = val[KROW_BITS-1:0];
            REG_KERNEL_BOTTOM: kern[2] = val[KROW_BITS-1:0];
            REG_IMAGE_WIDTH:   cfg_w   = val[CNT_BITS-1:0];
            REG_IMAGE_HEIGHT:  cfg_h   = val[CNT_BITS-1:0];
            default: ;
        endcase
    endtask

    // unused upper bits of each word are filled with junk
    task automatic load_config(input logic [KROW_BITS-1:0] k_top, k_mid, k_bot,
                               input logic [CNT_BITS-1:0] w, h);
        write_reg(REG_KERNEL_TOP,    {16'($urandom), k_top});
        write_reg(REG_KERNEL_MIDDLE, {16'($urandom), k_mid});
        write_reg(REG_KERNEL_BOTTOM, {16'($urandom), k_bot});
        write_reg(REG_IMAGE_WIDTH,   {$urandom, 26'($urandom), w});
        write_reg(REG_IMAGE_HEIGHT,  {$urandom, 26'($urandom), h});
        cfg_count++;
    endtask

    function automatic logic [KROW_BITS-1:0] rand_krow();
        logic [KROW_BITS-1:0] k;
        int unsigned          pick;
        for (int c = 0; c < 3; c++) begin
            pick = $urandom_range(99);
            if (pick < 20)      k[c*16 +: 16] = 16'h8000;
            else if (pick < 35) k[c*16 +: 16] = 16'h7fff;
            else if (pick < 45) k[c*16 +: 16] = 16'h0000;
            else if (pick < 60) k[c*16 +: 16] = 16'($signed($urandom_range(8)) - 4);
            else                k[c*16 +: 16] = 16'($urandom);
        end
        return k;
    endfunction

    function automatic t_pixel rand_pixel();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 15) return 16'sh8000;
        if (pick < 30) return 16'sh7fff;
        if (pick < 35) return '0;
        return t_pixel'($urandom);
    endfunction

    function automatic void add_pixel(input t_pixel v, input logic start);
        t_pix_in px;
        px.pixel_value = v;
        px.frame_start = start;
        pix_q.push_back(px);
        items_total++;
    endfunction

    function automatic void add_frame(input int unsigned npx, input logic start);
        for (int unsigned i = 0; i < npx; i++) add_pixel(rand_pixel(), start && i == 0);
    endfunction

    // wait until every pixel is in and every window is out, then let the pipe settle
    task automatic drain();
        do @(negedge i_clk);
        while (pix_q.size() != 0 || i_in_valid || sum_q.size() != 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    initial begin
        int unsigned          phase_no;
        int unsigned          pick;
        int unsigned          fpx;
        int unsigned          nfr;
        logic [CNT_BITS-1:0]  w_raw;
        logic [CNT_BITS-1:0]  h_raw;
        t_pixel               alt [9];

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // most negative coefficients against both pixel extremes, second frame wraps
        load_config({3{16'h8000}}, {3{16'h8000}}, {3{16'h8000}}, 6'd3, 6'd3);
        @(negedge i_clk);
        for (int i = 0; i < 9; i++) add_pixel(16'sh8000, i == 0);
        for (int i = 0; i < 9; i++) add_pixel(16'sh7fff, 1'b0);
        drain();

        // sizes below the minimum, mixed taps, frame restarted after one pixel
        load_config({16'h7fff, 16'h0001, 16'h8000}, {16'hffff, 16'h0000, 16'h7fff},
                    {16'h8000, 16'h7fff, 16'h0002}, 6'd2, 6'd0);
        alt = '{16'sh7fff, 16'sh8000, 16'sh0000, 16'sh0001, -16'sd1,
                16'sh7fff, 16'sh5555, 16'shaaaa, 16'sh8000};
        @(negedge i_clk);
        add_pixel(16'sh1234, 1'b1);
        for (int i = 0; i < 9; i++) add_pixel(alt[i], i == 0);
        drain();

        phase_no = 0;
        while (items_total < ITEMS) begin
            pick = $urandom_range(99);
            if (pick < 60)      w_raw = CNT_BITS'($urandom_range(8, 3));
            else if (pick < 80) w_raw = CNT_BITS'($urandom_range(32, 9));
            else if (pick < 90) w_raw = CNT_BITS'($urandom_range(2, 0));
            else                w_raw = CNT_BITS'($urandom_range(63, 33));
            pick = $urandom_range(99);
            if (pick < 60)      h_raw = CNT_BITS'($urandom_range(8, 3));
            else if (pick < 75) h_raw = CNT_BITS'($urandom_range(16, 9));
            else if (pick < 85) h_raw = CNT_BITS'($urandom_range(2, 0));
            else                h_raw = CNT_BITS'($urandom_range(63, 33));
            if (eff_w(w_raw) * eff_h(h_raw) > 160)
                h_raw = CNT_BITS'($urandom_range(160 / eff_w(w_raw), 3));
            fpx = eff_w(w_raw) * eff_h(h_raw);

            load_config(rand_krow(), rand_krow(), rand_krow(), w_raw, h_raw);
            @(posedge i_clk);
            send_idle <= (phase_no == 0) ? 0 : 24;
            recv_idle <= (phase_no == 0) ? 0 : 24;

            @(negedge i_clk);
            nfr = 200 / fpx;
            if (nfr < 1) nfr = 1;
            if (nfr > 3) nfr = 3;
            nfr = $urandom_range(nfr, 1);
            for (int f = 0; f < nfr && items_total < ITEMS; f++) begin
                pick = $urandom_range(99);
                if (pick < 75)      add_frame(fpx, 1'b1);
                else if (pick < 85) add_frame(fpx, 1'b0);
                else if (pick < 93) add_frame($urandom_range(fpx - 1, 1), 1'b1);
                else repeat ($urandom_range(8, 1)) add_pixel(rand_pixel(), $urandom_range(3) == 0);
            end
            if (phase_no <= 1) while (pix_q.size() < 60) add_frame(fpx, 1'b1);
            // leave a frame partly done so the next sizes land mid-frame
            if (items_total < ITEMS && $urandom_range(99) < 30)
                add_frame($urandom_range(fpx - 1, 1), 1'b1);
            if (phase_no == 1) begin
                @(posedge i_clk);
                hold_req <= 1'b1;
            end
            drain();
            phase_no++;
        end

        repeat (20) @(posedge i_clk);
        $display("run covered %0d pixels and %0d checked windows over %0d register settings",
            pix_count, res_count, cfg_count);
        $display("long output stall of %0d cycles applied, %0d mismatches seen",
            HOLD_CYCLES, err_count);
        if (err_count == 0 && sum_q.size() == 0) begin
            $display("tb_conv3x3_valid_stream: done, clean");
        end else begin
            $display("tb_conv3x3_valid_stream: done, errors");
        end
        $finish;
    end

endmodule

/* conv3x3_valid_stream.f */
sv/c3v_pkg.sv
sv/c3v_ram.sv
sv/c3v_cell.sv
sv/conv3x3_valid_stream.sv
tb/sv/tb_conv3x3_valid_stream.sv
